// File: hdl/qtse_pkg.sv
// ----------------------------------------------------------------------------
// qtse_pkg
// Shared types and constants of the quadratic tetrahedron shape evaluator.
// ----------------------------------------------------------------------------
package qtse_pkg;

    // field widths of the stream items
    localparam int COORD_W   = 17;
    localparam int OUT_W     = 22;
    localparam int IDX_W     = 4;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 96;

    // node numbering: corners first, then the six midside nodes
    typedef enum logic [IDX_W-1:0] {
        NODE_L0 = 4'd0,
        NODE_X  = 4'd1,
        NODE_Y  = 4'd2,
        NODE_Z  = 4'd3,
        NODE_XL = 4'd4,
        NODE_XY = 4'd5,
        NODE_YL = 4'd6,
        NODE_ZL = 4'd7,
        NODE_XZ = 4'd8,
        NODE_YZ = 4'd9
    } node_t;

    localparam node_t NODE_FIRST = NODE_L0;
    localparam node_t NODE_LAST  = NODE_YZ;

endpackage

// File: hdl/quadratic_tetra_shape_eval.sv
// Each accepted point is captured by the node sequencer, and each node then passes
// through stage 1, stage 2 and the output register. While the output is not held, the
// node sequencer issues one node per cycle into the multiply pipeline, one node result per cycle.
// Reset: rst_n clears the sequencer and all valid bits asynchronously;
// data registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_tetra_shape_eval
// Ten-node quadratic tetrahedron shape functions and local derivatives at one
// point, emitted as ten node items (node 0 to 9) per input point.
// ----------------------------------------------------------------------------
module quadratic_tetra_shape_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coord_x, coord_y, coord_z (lowest bit up), zero padded
    input  logic [qtse_pkg::S_TDATA_W-1:0]   s_tdata,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // node_index, shape_value, deriv_x, deriv_y, deriv_z (lowest bit up), zero padded
    output logic [qtse_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import qtse_pkg::*;

    // internal widths follow the larger of fraction and coordinate width
    localparam int MW  = (FRAC_BITS > COORD_W) ? FRAC_BITS : COORD_W;
    localparam int OPW = MW + 5;
    localparam int DW  = MW + 6;
    localparam int PRW = 2 * OPW;
    localparam int PW  = PRW + 2;
    localparam int PAD = M_TDATA_W - IDX_W - 4 * OUT_W;

    localparam logic signed [DW-1:0] ONE_D  = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] DHI    = DW'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [DW-1:0] DLO    = -DHI - DW'(1);
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] PHI    = PW'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [PW-1:0] PLO    = -PHI - PW'(1);

    function automatic logic signed [OUT_W-1:0] sat_d(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] t;
        t = (v > DHI) ? DHI : ((v < DLO) ? DLO : v);
        return t[OUT_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_p(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v > PHI) ? PHI : ((v < PLO) ? PLO : v);
        return t[OUT_W-1:0];
    endfunction

    // sequencer state
    logic                       busy_reg;
    node_t                      node_reg;
    logic [COORD_W-1:0]         x_reg, y_reg, z_reg;

    // stage 1: operands and derivatives
    logic                       p1_valid_reg;
    node_t                      p1_node_reg;
    logic                       p1_mid_reg;
    logic signed [OPW-1:0]      p1_a_reg, p1_b_reg;
    logic signed [DW-1:0]       p1_dx_reg, p1_dy_reg, p1_dz_reg;

    // stage 2: product
    logic                       p2_valid_reg;
    node_t                      p2_node_reg;
    logic                       p2_mid_reg;
    logic signed [PRW-1:0]      p2_prod_reg;
    logic signed [OUT_W-1:0]    p2_dx_reg, p2_dy_reg, p2_dz_reg;

    // output register
    logic                       out_valid_reg;
    node_t                      out_node_reg;
    logic signed [OUT_W-1:0]    out_shape_reg, out_dx_reg, out_dy_reg, out_dz_reg;
    logic                       out_last_reg;

    logic                       adv;
    logic                       in_acc;
    logic                       issue;

    logic signed [DW-1:0]       x_d, y_d, z_d, s_d, l0_d;
    logic signed [OPW-1:0]      a_next, b_next;
    logic                       mid_next;
    logic signed [DW-1:0]       dx_next, dy_next, dz_next;
    logic signed [PRW-1:0]      prod_next;
    logic signed [PW-1:0]       prod_ext, scaled, rsum, rounded;
    logic signed [OUT_W-1:0]    shape_next;

    // flow control: the whole pipe moves unless the output item is held
    assign adv      = !(out_valid_reg && !m_tready);
    assign s_tready = adv && (!busy_reg || (node_reg == NODE_LAST));
    assign in_acc   = s_tvalid && s_tready;
    assign issue    = busy_reg && adv;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            node_reg <= NODE_FIRST;
        end
        else if (in_acc)
        begin
            busy_reg <= 1'b1;
            node_reg <= NODE_FIRST;
        end
        else if (issue)
        begin
            if (node_reg == NODE_LAST)
            begin
                busy_reg <= 1'b0;
                node_reg <= NODE_FIRST;
            end
            else
            begin
                node_reg <= node_t'(IDX_W'(node_reg + IDX_W'(1)));
            end
        end
    end

    // point capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= s_tdata[COORD_W-1:0];
            y_reg <= s_tdata[2*COORD_W-1:COORD_W];
            z_reg <= s_tdata[3*COORD_W-1:2*COORD_W];
        end
    end

    // per-node operand pair and derivatives
    always_comb
    begin
        x_d  = $signed({{(DW-COORD_W){1'b0}}, x_reg});
        y_d  = $signed({{(DW-COORD_W){1'b0}}, y_reg});
        z_d  = $signed({{(DW-COORD_W){1'b0}}, z_reg});
        s_d  = x_d + y_d + z_d;
        l0_d = ONE_D - s_d;
        a_next   = '0;
        b_next   = '0;
        mid_next = 1'b0;
        dx_next  = '0;
        dy_next  = '0;
        dz_next  = '0;
        unique case (node_reg)
            NODE_L0:
            begin
                a_next  = l0_d[OPW-1:0];
                b_next  = OPW'(ONE_D - (s_d <<< 1));
                dx_next = (s_d <<< 2) - ONE_D - (ONE_D <<< 1);
                dy_next = (s_d <<< 2) - ONE_D - (ONE_D <<< 1);
                dz_next = (s_d <<< 2) - ONE_D - (ONE_D <<< 1);
            end
            NODE_X:
            begin
                a_next  = x_d[OPW-1:0];
                b_next  = OPW'((x_d <<< 1) - ONE_D);
                dx_next = (x_d <<< 2) - ONE_D;
            end
            NODE_Y:
            begin
                a_next  = y_d[OPW-1:0];
                b_next  = OPW'((y_d <<< 1) - ONE_D);
                dy_next = (y_d <<< 2) - ONE_D;
            end
            NODE_Z:
            begin
                a_next  = z_d[OPW-1:0];
                b_next  = OPW'((z_d <<< 1) - ONE_D);
                dz_next = (z_d <<< 2) - ONE_D;
            end
            NODE_XL:
            begin
                a_next   = x_d[OPW-1:0];
                b_next   = l0_d[OPW-1:0];
                mid_next = 1'b1;
                dx_next  = (ONE_D <<< 2) - (x_d <<< 3) - (y_d <<< 2) - (z_d <<< 2);
                dy_next  = -(x_d <<< 2);
                dz_next  = -(x_d <<< 2);
            end
            NODE_XY:
            begin
                a_next   = x_d[OPW-1:0];
                b_next   = y_d[OPW-1:0];
                mid_next = 1'b1;
                dx_next  = y_d <<< 2;
                dy_next  = x_d <<< 2;
            end
            NODE_YL:
            begin
                a_next   = y_d[OPW-1:0];
                b_next   = l0_d[OPW-1:0];
                mid_next = 1'b1;
                dx_next  = -(y_d <<< 2);
                dy_next  = (ONE_D <<< 2) - (y_d <<< 3) - (x_d <<< 2) - (z_d <<< 2);
                dz_next  = -(y_d <<< 2);
            end
            NODE_ZL:
            begin
                a_next   = z_d[OPW-1:0];
                b_next   = l0_d[OPW-1:0];
                mid_next = 1'b1;
                dx_next  = -(z_d <<< 2);
                dy_next  = -(z_d <<< 2);
                dz_next  = (ONE_D <<< 2) - (z_d <<< 3) - (x_d <<< 2) - (y_d <<< 2);
            end
            NODE_XZ:
            begin
                a_next   = x_d[OPW-1:0];
                b_next   = z_d[OPW-1:0];
                mid_next = 1'b1;
                dx_next  = z_d <<< 2;
                dz_next  = x_d <<< 2;
            end
            NODE_YZ:
            begin
                a_next   = y_d[OPW-1:0];
                b_next   = z_d[OPW-1:0];
                mid_next = 1'b1;
                dy_next  = z_d <<< 2;
                dz_next  = y_d <<< 2;
            end
            default:
            begin
                a_next   = '0;
                b_next   = '0;
                mid_next = 1'b0;
            end
        endcase
    end

    // product of the operand pair
    assign prod_next = p1_a_reg * p1_b_reg;

    // scale midside products by four, round once, saturate
    always_comb
    begin
        prod_ext   = PW'(p2_prod_reg);
        scaled     = p2_mid_reg ? (prod_ext <<< 2) : prod_ext;
        rsum       = scaled + HALF_P;
        rounded    = rsum >>> FRAC_BITS;
        shape_next = sat_p(rounded);
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= busy_reg;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_node_reg   <= node_reg;
            p1_mid_reg    <= mid_next;
            p1_a_reg      <= a_next;
            p1_b_reg      <= b_next;
            p1_dx_reg     <= dx_next;
            p1_dy_reg     <= dy_next;
            p1_dz_reg     <= dz_next;

            p2_node_reg   <= p1_node_reg;
            p2_mid_reg    <= p1_mid_reg;
            p2_prod_reg   <= prod_next;
            p2_dx_reg     <= sat_d(p1_dx_reg);
            p2_dy_reg     <= sat_d(p1_dy_reg);
            p2_dz_reg     <= sat_d(p1_dz_reg);

            out_node_reg  <= p2_node_reg;
            out_shape_reg <= shape_next;
            out_dx_reg    <= p2_dx_reg;
            out_dy_reg    <= p2_dy_reg;
            out_dz_reg    <= p2_dz_reg;
            out_last_reg  <= (p2_node_reg == NODE_LAST);
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD{1'b0}}, out_dz_reg, out_dy_reg, out_dx_reg, out_shape_reg,
                       out_node_reg};

`ifndef SYNTHESIS
    // the run ends on the last node only
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[IDX_W-1:0] == NODE_LAST)
        else $error("tlast on a node other than the last");

    // no new point while a run is still being issued
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (node_reg != NODE_LAST) |-> !s_tready)
        else $error("input accepted in the middle of a run");

    // an accepted point starts its run at the first node
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> busy_reg && (node_reg == NODE_FIRST))
        else $error("run did not start at the first node");

    // the sequencer only issues into a moving pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> p1_valid_reg && (p1_node_reg == $past(node_reg)))
        else $error("issued node lost in the first stage");
`endif

endmodule

// File: bench/quadratic_tetra_shape_eval_test.sv
// ----------------------------------------------------------------------------
// quadratic_tetra_shape_eval_test
// Self-checking bench for the ten-node tetrahedron shape evaluator. Points go
// in on the input stream. A bit-exact model predicts all ten node items of
// each accepted point, and every item that comes out is compared with them.
// Both sides idle at random, and the run includes one long output stall and
// points outside the unit tetrahedron.
// ----------------------------------------------------------------------------
module quadratic_tetra_shape_eval_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qtse_pkg::*;

    localparam int    FRAC_BITS     = 16;
    localparam int    RANDOM_POINTS = 138;
    localparam int    QUIET_POINTS  = 40;
    localparam int    HOLD_CYCLES   = 60;
    localparam int    DRAIN_LIMIT   = 5000;
    localparam int    SHAPE_LSB     = IDX_W;
    localparam int    DX_LSB        = SHAPE_LSB + OUT_W;
    localparam int    DY_LSB        = DX_LSB + OUT_W;
    localparam int    DZ_LSB        = DY_LSB + OUT_W;
    localparam longint OUT_HI       = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO       = -(64'sd1 <<< (OUT_W - 1));

    // one node item as the block should deliver it
    typedef struct {
        node_t                   node;
        logic signed [OUT_W-1:0] shape;
        logic signed [OUT_W-1:0] dx;
        logic signed [OUT_W-1:0] dy;
        logic signed [OUT_W-1:0] dz;
        logic                    last;
    } node_item_t;

    // ------------------------------------------------------------------------
    // shape function predictor and node item checker
    // ------------------------------------------------------------------------
    class shape_scoreboard;
        node_item_t  expected_nodes[$];
        int unsigned points_seen;
        int unsigned items_checked;
        int unsigned mismatches;

        function new();
            points_seen   = 0;
            items_checked = 0;
            mismatches    = 0;
        endfunction

        function logic signed [OUT_W-1:0] clip(longint v);
            if (v > OUT_HI)
                return OUT_HI[OUT_W-1:0];
            if (v < OUT_LO)
                return OUT_LO[OUT_W-1:0];
            return v[OUT_W-1:0];
        endfunction

        // all ten node items of one accepted point
        function void note_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                 logic [COORD_W-1:0] cz);
            longint     one;
            longint     x;
            longint     y;
            longint     z;
            longint     l0;
            longint     unit;
            longint     sv[10];
            longint     dv[10][3];
            node_item_t item;

            one = 64'sd1 <<< FRAC_BITS;
            x   = longint'(cx);
            y   = longint'(cy);
            z   = longint'(cz);
            l0  = one - x - y - z;

            // midside products keep twice the fraction bits
            sv[4] = 4 * x * l0;
            sv[5] = 4 * x * y;
            sv[6] = 4 * y * l0;
            sv[7] = 4 * z * l0;
            sv[8] = 4 * x * z;
            sv[9] = 4 * y * z;
            // corners: linear value less half the adjacent midsides
            sv[0] = l0 * one - (sv[4] + sv[6] + sv[7]) / 2;
            sv[1] = x * one - (sv[4] + sv[5] + sv[8]) / 2;
            sv[2] = y * one - (sv[5] + sv[6] + sv[9]) / 2;
            sv[3] = z * one - (sv[8] + sv[7] + sv[9]) / 2;

            // midside derivatives
            dv[4][0] = 4 * one - 8 * x - 4 * y - 4 * z;
            dv[4][1] = -4 * x;
            dv[4][2] = -4 * x;
            dv[5][0] = 4 * y;
            dv[5][1] = 4 * x;
            dv[5][2] = 0;
            dv[6][0] = -4 * y;
            dv[6][1] = 4 * one - 8 * y - 4 * x - 4 * z;
            dv[6][2] = -4 * y;
            dv[7][0] = -4 * z;
            dv[7][1] = -4 * z;
            dv[7][2] = 4 * one - 8 * z - 4 * x - 4 * y;
            dv[8][0] = 4 * z;
            dv[8][1] = 0;
            dv[8][2] = 4 * x;
            dv[9][0] = 0;
            dv[9][1] = 4 * z;
            dv[9][2] = 4 * y;
            // corner derivatives
            for (int k = 0; k < 3; k++)
            begin
                dv[0][k] = -one - (dv[4][k] + dv[6][k] + dv[7][k]) / 2;
                unit = (k == 0) ? one : 0;
                dv[1][k] = unit - (dv[4][k] + dv[5][k] + dv[8][k]) / 2;
                unit = (k == 1) ? one : 0;
                dv[2][k] = unit - (dv[5][k] + dv[6][k] + dv[9][k]) / 2;
                unit = (k == 2) ? one : 0;
                dv[3][k] = unit - (dv[9][k] + dv[7][k] + dv[8][k]) / 2;
            end

            // round shape values to nearest, ties up, then saturate
            for (int k = 0; k < 10; k++)
            begin
                item.node  = node_t'(k);
                item.shape = clip((sv[k] + one / 2) >>> FRAC_BITS);
                item.dx    = clip(dv[k][0]);
                item.dy    = clip(dv[k][1]);
                item.dz    = clip(dv[k][2]);
                item.last  = (item.node == NODE_LAST);
                expected_nodes.push_back(item);
            end
            points_seen++;
        endfunction

        // compare one accepted node item with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] data, logic tlast);
            node_item_t want;
            node_item_t got;

            items_checked++;
            got.node  = node_t'(data[IDX_W-1:0]);
            got.shape = data[SHAPE_LSB +: OUT_W];
            got.dx    = data[DX_LSB +: OUT_W];
            got.dy    = data[DY_LSB +: OUT_W];
            got.dz    = data[DZ_LSB +: OUT_W];
            got.last  = tlast;
            if (expected_nodes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected node item: node %0d shape %0d", got.node, got.shape);
                return;
            end
            want = expected_nodes.pop_front();
            if (got.node !== want.node || got.shape !== want.shape || got.dx !== want.dx ||
                got.dy !== want.dy || got.dz !== want.dz || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch  expected: node %0d shape %0d d %0d %0d %0d last %0b",
                             want.node, want.shape, want.dx, want.dy, want.dz, want.last);
                    $display("          actual:   node %0d shape %0d d %0d %0d %0d last %0b",
                             got.node, got.shape, got.dx, got.dy, got.dz, got.last);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_nodes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // coord_x, coord_y, coord_z (lowest bit up), zero padded
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // node_index, shape_value, deriv_x, deriv_y, deriv_z (lowest bit up), zero padded
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    shape_scoreboard      sb;
    bit                   hold_request = 1'b0;
    bit                   quiet_phase  = 1'b0;

    quadratic_tetra_shape_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // both handshakes are sampled mid-cycle, where nothing moves
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata[0 +: COORD_W], s_tdata[COORD_W +: COORD_W],
                              s_tdata[2*COORD_W +: COORD_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
        end
    end

    // result side: random stall bursts and one long hold on request
    initial
    begin : result_sink
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // offer one point and hold it until it is taken
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 3*COORD_W){1'b0}}, z, y, x};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // input side idles, with junk on the data lines
    task automatic idle_gap(input int unsigned cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= S_TDATA_W'({$urandom, $urandom});
        repeat (cycles) @(posedge clk);
    endtask

    // pause the input until every predicted node item has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // run limit
    initial
    begin : watchdog
        #2000000;
        $display("quadratic_tetra_shape_eval_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        logic [COORD_W-1:0] pt;
        int unsigned        pick;
        int unsigned        spin;

        sb = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners, edge midpoints, centroid, centroid of the far face
        send_point(17'd0, 17'd0, 17'd0);
        send_point(17'd65536, 17'd0, 17'd0);
        send_point(17'd0, 17'd65536, 17'd0);
        send_point(17'd0, 17'd0, 17'd65536);
        send_point(17'd32768, 17'd0, 17'd0);
        send_point(17'd32768, 17'd32768, 17'd0);
        send_point(17'd0, 17'd32768, 17'd32768);
        send_point(17'd32768, 17'd0, 17'd32768);
        send_point(17'd16384, 17'd16384, 17'd16384);
        send_point(17'd21845, 17'd21845, 17'd21846);
        // exact rounding ties and one-lsb coordinates
        send_point(17'd128, 17'd64, 17'd0);
        send_point(17'd0, 17'd64, 17'd128);
        send_point(17'd1, 17'd1, 17'd1);
        send_point(17'd65535, 17'd0, 17'd1);
        // out of range points drive the outputs into saturation
        send_point(17'd131071, 17'd0, 17'd0);
        send_point(17'd0, 17'd131071, 17'd0);
        send_point(17'd0, 17'd0, 17'd131071);
        send_point(17'd131071, 17'd131071, 17'd131071);
        send_point(17'd65536, 17'd65536, 17'd65536);
        send_point(17'd98304, 17'd98304, 17'd0);
        wait_drained();

        // long output stall while points keep coming
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_point(COORD_W'($urandom_range(0, 65536)), COORD_W'($urandom_range(0, 32768)),
                       COORD_W'($urandom_range(0, 16384)));
        wait_drained();

        // random points: mostly inside the element, some outside
        for (int i = 0; i < RANDOM_POINTS; i++)
        begin
            if (i == RANDOM_POINTS - QUIET_POINTS)
                quiet_phase = 1'b1;
            if (i == RANDOM_POINTS / 2)
                wait_drained();
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                px = COORD_W'($urandom_range(0, 65536));
                py = COORD_W'($urandom_range(0, 65536 - px));
                pz = ($urandom_range(0, 3) == 0) ? 17'(65536 - px - py)
                                                 : 17'($urandom_range(0, 65536 - px - py));
                // spread the large share over all three coordinates
                repeat ($urandom_range(0, 2))
                begin
                    pt = px;
                    px = py;
                    py = pz;
                    pz = pt;
                end
            end
            else if (pick < 85)
            begin
                px = COORD_W'($urandom_range(0, 65536));
                py = COORD_W'($urandom_range(0, 65536));
                pz = COORD_W'($urandom_range(0, 65536));
            end
            else
            begin
                px = COORD_W'($urandom_range(0, 131071));
                py = COORD_W'($urandom_range(0, 131071));
                pz = COORD_W'($urandom_range(0, 131071));
            end
            send_point(px, py, pz);
        end
        s_tvalid <= 1'b0;

        // let the last node items out
        for (spin = 0; spin < DRAIN_LIMIT && sb.pending() != 0; spin++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d points (corners, edges, ties, saturating and random) and %0d node items",
                 sb.points_seen, sb.items_checked);
        $display("mismatches %0d, node items still expected %0d", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("quadratic_tetra_shape_eval_test: PASS");
        else
            $display("quadratic_tetra_shape_eval_test: FAIL");
        $finish;
    end

endmodule

// File: quadratic_tetra_shape_eval.f
hdl/qtse_pkg.sv
hdl/quadratic_tetra_shape_eval.sv
bench/quadratic_tetra_shape_eval_test.sv
